// ----- hdl/scsd_pkg.sv -----
// Package for the session code stream decoder.
// Holds status and phase codes, constants and the base64/CRC helper functions.
// No dependencies.
package scsd_pkg;

	localparam int unsigned ScratchBytes = 4096;
	localparam int unsigned CntW = $clog2(ScratchBytes + 1);

	localparam logic [31:0] CrcPoly = 32'hEDB88320;
	localparam logic [31:0] CrcInit = 32'hFFFFFFFF;

	typedef enum logic [3:0] {
		ST_OK          = 4'd0,
		ST_BAD_CHAR    = 4'd1,
		ST_TOO_LONG    = 4'd2,
		ST_TRUNCATED   = 4'd3,
		ST_MAGIC       = 4'd4,
		ST_VERSION     = 4'd5,
		ST_CRC         = 4'd6,
		ST_ROLE        = 4'd7,
		ST_MALFORMED   = 4'd8,
		ST_EMPTY_DESC  = 4'd9,
		ST_LEN_MISSING = 4'd10,
		ST_CAND_TRUNC  = 4'd11,
		ST_EMPTY_CAND  = 4'd12
	} status_t;

	typedef enum logic [2:0] {
		PH_HEADER = 3'd0,
		PH_DESC   = 3'd1,
		PH_LEN_LO = 3'd2,
		PH_LEN_HI = 3'd3,
		PH_CDATA  = 3'd4,
		PH_DONE   = 3'd5,
		PH_STOP   = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		REG_MAX_DESC  = 2'd0,
		REG_MAX_CANDS = 2'd1,
		REG_MAX_CLEN  = 2'd2,
		REG_MAX_ROLE  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [11:0] max_desc;
		logic [7:0]  max_cands;
		logic [11:0] max_clen;
		logic [7:0]  max_role;
	} cfg_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       data_valid;
		logic       data_kind;
		logic [7:0] candidate_number;
		logic       done_res;
		logic [3:0] status;
	} result_t;

	function automatic logic [7:0] magic_byte(input logic [1:0] pos);
		case (pos)
			2'd0:    magic_byte = 8'h54;
			2'd1:    magic_byte = 8'h4C;
			2'd2:    magic_byte = 8'h53;
			default: magic_byte = 8'h31;
		endcase
	endfunction

	// 7-bit sextet; bit 6 set means not a base64url character
	function automatic logic [6:0] sextet_of(input logic [7:0] c);
		logic [6:0] v;
		v = 7'h40;
		if (c >= 8'h41 && c <= 8'h5A) v = 7'(c - 8'h41);
		else if (c >= 8'h61 && c <= 8'h7A) v = 7'(c - 8'h61 + 8'd26);
		else if (c >= 8'h30 && c <= 8'h39) v = 7'(c - 8'h30 + 8'd52);
		else if (c == 8'h2D) v = 7'd62;
		else if (c == 8'h5F) v = 7'd63;
		return v;
	endfunction

	function automatic logic is_skip(input logic [7:0] c);
		return (c == 8'h20) || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A) || (c == 8'h3D);
	endfunction

	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] r;
		r = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			r = (r >> 1) ^ (r[0] ? CrcPoly : 32'd0);
		end
		return r;
	endfunction

endpackage

// ----- hdl/scsd_cfg_regs.sv -----
// Configuration registers of the session code stream decoder.
// Depends on scsd_pkg.
module scsd_cfg_regs import scsd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data,
	input  logic        cfg_in_range,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_desc  <= 12'd2048;
			cfg_q.max_cands <= 8'd16;
			cfg_q.max_clen  <= 12'd256;
			cfg_q.max_role  <= 8'd1;
		end else if (cfg_valid && cfg_in_range) begin
			unique case (reg_idx_t'(cfg_index))
				REG_MAX_DESC:  cfg_q.max_desc  <= cfg_data;
				REG_MAX_CANDS: cfg_q.max_cands <= cfg_data[7:0];
				REG_MAX_CLEN:  cfg_q.max_clen  <= cfg_data;
				REG_MAX_ROLE:  cfg_q.max_role  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

endmodule

// ----- hdl/scsd_decode_core.sv -----
// Decoder datapath: base64url unpack, tail delay, CRC-32 and record parser.
// One character per cycle while in_go is high, from the sym input into a result register.
// Depends on scsd_pkg.
module scsd_decode_core import scsd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_go,
	input  logic [7:0] sym,
	input  logic       last,
	input  cfg_t       cfg,
	output result_t    res
);

	logic [5:0]      left_bits_q;
	logic [2:0]      left_cnt_q;
	logic [CntW-1:0] byte_cnt_q;
	logic [7:0]      tail_q [4];
	logic [31:0]     crc_q;
	phase_t          phase_q;
	logic [31:0]     rem_q;
	logic [15:0]     cands_q;
	logic [7:0]      cidx_q;
	logic [3:0]      err_q;

	logic [5:0]      left_bits_d;
	logic [2:0]      left_cnt_d;
	logic [CntW-1:0] byte_cnt_d;
	logic [7:0]      tail_d [4];
	logic [31:0]     crc_d;
	phase_t          phase_d;
	logic [31:0]     rem_d;
	logic [15:0]     cands_d;
	logic [7:0]      cidx_d;
	logic [3:0]      err_d;
	result_t         res_d;

	logic [6:0]  sx;
	logic [11:0] acc;
	logic [3:0]  n;
	logic [7:0]  nb;
	logic [7:0]  old;
	logic [CntW-1:0] pos;
	logic [31:0] tailw;
	logic [31:0] rem_m1;
	logic [15:0] clen;
	logic [3:0]  fin;

	always_comb begin
		left_bits_d = left_bits_q;
		left_cnt_d  = left_cnt_q;
		byte_cnt_d  = byte_cnt_q;
		tail_d      = tail_q;
		crc_d       = crc_q;
		phase_d     = phase_q;
		rem_d       = rem_q;
		cands_d     = cands_q;
		cidx_d      = cidx_q;
		err_d       = err_q;
		res_d       = '0;
		sx          = sextet_of(sym);
		acc         = {left_bits_q, sx[5:0]};
		n           = 4'(left_cnt_q) + 4'd6;
		nb          = '0;
		old         = tail_q[0];
		pos         = byte_cnt_q - CntW'(4);
		rem_m1      = rem_q - 32'd1;
		clen        = '0;
		fin         = ST_OK;

		if (err_q != ST_BAD_CHAR && err_q != ST_TOO_LONG && !is_skip(sym)) begin
			if (sx[6]) begin
				err_d = ST_BAD_CHAR;
			end else begin
				if (n >= 4'd8) begin
					n = n - 4'd8;
					if (byte_cnt_q >= CntW'(ScratchBytes)) begin
						err_d = ST_TOO_LONG;
					end else begin
						nb = 8'(acc >> n);
						if (byte_cnt_q >= CntW'(4)) begin
							crc_d = crc_byte(crc_q, old);
							case (phase_q)
								PH_HEADER: begin
									if (pos < CntW'(4)) begin
										if (old != magic_byte(pos[1:0])) begin
											err_d = ST_MAGIC; phase_d = PH_STOP;
										end
									end else if (pos == CntW'(4)) begin
										if (old != 8'd1) begin
											err_d = ST_VERSION; phase_d = PH_STOP;
										end
									end else if (pos == CntW'(5)) begin
										if (old > cfg.max_role) begin
											err_d = ST_ROLE; phase_d = PH_STOP;
										end
									end else if (pos == CntW'(6)) begin
										cands_d = {8'd0, old};
									end else if (pos == CntW'(7)) begin
										cands_d = {old, cands_q[7:0]};
									end else begin
										case (pos[1:0])
											2'd0:    rem_d = rem_q | {24'd0, old};
											2'd1:    rem_d = rem_q | {16'd0, old, 8'd0};
											2'd2:    rem_d = rem_q | {8'd0, old, 16'd0};
											default: rem_d = rem_q | {old, 24'd0};
										endcase
										if (pos == CntW'(11)) begin
											if (cands_q > {8'd0, cfg.max_cands} ||
											    rem_d > {20'd0, cfg.max_desc}) begin
												err_d = ST_MALFORMED; phase_d = PH_STOP;
											end else if (rem_d == 32'd0) begin
												err_d = ST_EMPTY_DESC; phase_d = PH_STOP;
											end else begin
												phase_d = PH_DESC;
											end
										end
									end
								end
								PH_DESC: begin
									res_d.data_byte  = old;
									res_d.data_valid = 1'b1;
									rem_d = rem_m1;
									if (rem_m1 == 32'd0)
										phase_d = (cands_q != 16'd0) ? PH_LEN_LO : PH_DONE;
								end
								PH_LEN_LO: begin
									rem_d = {24'd0, old};
									phase_d = PH_LEN_HI;
								end
								PH_LEN_HI: begin
									clen = {old, rem_q[7:0]};
									rem_d = {16'd0, clen};
									if (clen > {4'd0, cfg.max_clen}) begin
										err_d = ST_CAND_TRUNC; phase_d = PH_STOP;
									end else if (clen == 16'd0) begin
										err_d = ST_EMPTY_CAND; phase_d = PH_STOP;
									end else begin
										phase_d = PH_CDATA;
									end
								end
								PH_CDATA: begin
									res_d.data_byte        = old;
									res_d.data_valid       = 1'b1;
									res_d.data_kind        = 1'b1;
									res_d.candidate_number = cidx_q;
									rem_d = rem_m1;
									if (rem_m1 == 32'd0) begin
										cands_d = cands_q - 16'd1;
										cidx_d  = cidx_q + 8'd1;
										phase_d = (cands_q != 16'd1) ? PH_LEN_LO : PH_DONE;
									end
								end
								default: ;
							endcase
						end
						tail_d[0] = tail_q[1];
						tail_d[1] = tail_q[2];
						tail_d[2] = tail_q[3];
						tail_d[3] = nb;
						byte_cnt_d = byte_cnt_q + CntW'(1);
					end
				end
				left_bits_d = 6'(acc & ((12'd1 << n) - 12'd1));
				left_cnt_d  = n[2:0];
			end
		end

		tailw = {tail_d[3], tail_d[2], tail_d[1], tail_d[0]};
		if (err_d == ST_BAD_CHAR || err_d == ST_TOO_LONG) fin = err_d;
		else if (byte_cnt_d < CntW'(16)) fin = ST_TRUNCATED;
		else if (err_d == ST_MAGIC || err_d == ST_VERSION) fin = err_d;
		else if (~crc_d != tailw) fin = ST_CRC;
		else if (err_d != ST_OK) fin = err_d;
		else begin
			case (phase_d)
				PH_DESC:              fin = ST_MALFORMED;
				PH_LEN_LO, PH_LEN_HI: fin = ST_LEN_MISSING;
				PH_CDATA:             fin = ST_CAND_TRUNC;
				PH_DONE:              fin = ST_OK;
				default:              fin = ST_TRUNCATED;
			endcase
		end
		if (last) begin
			res_d.done_res = 1'b1;
			res_d.status   = fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_bits_q <= '0;
			left_cnt_q  <= '0;
			byte_cnt_q  <= '0;
			tail_q      <= '{default: '0};
			crc_q       <= CrcInit;
			phase_q     <= PH_HEADER;
			rem_q       <= '0;
			cands_q     <= '0;
			cidx_q      <= '0;
			err_q       <= ST_OK;
		end else if (in_go) begin
			if (last) begin
				left_bits_q <= '0;
				left_cnt_q  <= '0;
				byte_cnt_q  <= '0;
				tail_q      <= '{default: '0};
				crc_q       <= CrcInit;
				phase_q     <= PH_HEADER;
				rem_q       <= '0;
				cands_q     <= '0;
				cidx_q      <= '0;
				err_q       <= ST_OK;
			end else begin
				left_bits_q <= left_bits_d;
				left_cnt_q  <= left_cnt_d;
				byte_cnt_q  <= byte_cnt_d;
				tail_q      <= tail_d;
				crc_q       <= crc_d;
				phase_q     <= phase_d;
				rem_q       <= rem_d;
				cands_q     <= cands_d;
				cidx_q      <= cidx_d;
				err_q       <= err_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_go) res <= res_d;
	end

endmodule

// ----- hdl/session_code_stream_decoder_core.sv -----
// Top level of the session code stream decoder.
// Depends on scsd_pkg, scsd_cfg_regs and scsd_decode_core.
//
// Decodes URL-safe base64 text, one character per transaction, into a framed
// record and gives exactly one result per character in the cycle after it is
// accepted. A character is taken every cycle; the output register only stalls
// the input when its result has not been taken. Decoded field bytes leave
// before the CRC is checked: keep them only if the final status is ok.
module session_code_stream_decoder_core import scsd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  symbol,
	input  logic        final_char,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  data_byte,
	output logic        data_valid,
	output logic        data_kind,
	output logic [7:0]  candidate_number,
	output logic        done_res,
	output logic [3:0]  status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [11:0] cfg_data
);

	cfg_t    cfg;
	result_t res;
	logic    out_valid_q;
	logic    in_go;

	assign in_ready = !out_valid_q || out_ready;
	assign in_go    = in_valid && in_ready;

	scsd_cfg_regs u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index[1:0]),
		.cfg_data     (cfg_data),
		.cfg_in_range (cfg_index[7:2] == 6'd0),
		.cfg          (cfg)
	);

	scsd_decode_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.in_go  (in_go),
		.sym    (symbol),
		.last   (final_char),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (in_ready) out_valid_q <= in_valid;
	end

	assign out_valid        = out_valid_q;
	assign data_byte        = res.data_byte;
	assign data_valid       = res.data_valid;
	assign data_kind        = res.data_kind;
	assign candidate_number = res.candidate_number;
	assign done_res         = res.done_res;
	assign status           = res.status;

endmodule

// ----- hdl/scsd_checker.sv -----
// Port-level checker for the session code stream decoder, bound to the top.
// Depends on scsd_pkg.
module scsd_port_checker import scsd_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       data_valid,
	input logic       data_kind,
	input logic [7:0] candidate_number,
	input logic       done_res,
	input logic [3:0] status
);

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid) else $error("missing result");

	a_ready_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready) else $error("input stalled while output empty");

	a_status_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !done_res |-> status == ST_OK) else $error("status without done");

	a_kind_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !(data_valid && data_kind) |-> candidate_number == 8'd0)
		else $error("stray candidate number");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status))
		else $error("result dropped while stalled");

endmodule

bind session_code_stream_decoder_core scsd_port_checker u_scsd_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_valid),
	.in_ready         (in_ready),
	.out_valid        (out_valid),
	.out_ready        (out_ready),
	.data_valid       (data_valid),
	.data_kind        (data_kind),
	.candidate_number (candidate_number),
	.done_res         (done_res),
	.status           (status)
);

// ----- test/scsd_checker.sv -----
// Checker for the session code stream decoder: watches the character, result and
// register write channels, predicts each result and compares field by field.
// Depends on scsd_pkg.
module scsd_checker import scsd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  symbol,
	input  logic        final_char,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [7:0]  data_byte,
	input  logic        data_valid,
	input  logic        data_kind,
	input  logic [7:0]  candidate_number,
	input  logic        done_res,
	input  logic [3:0]  status,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [11:0] cfg_data,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	cfg_t        lim;
	logic [5:0]  rem_bits;
	logic [2:0]  rem_cnt;
	logic [12:0] nbytes;
	logic [7:0]  hold [4];
	logic [31:0] crc;
	phase_t      phase;
	logic [31:0] field_left;
	logic [15:0] cands_left;
	logic [7:0]  cand_idx;
	status_t     err;
	result_t     expected_q [$];

	function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'd0, b};
		for (int k = 0; k < 8; k++)
			r = r[0] ? ((r >> 1) ^ 32'hEDB88320) : (r >> 1);
		return r;
	endfunction

	function automatic logic [7:0] sextet(input logic [7:0] c);
		if (c >= "A" && c <= "Z") return c - "A";
		if (c >= "a" && c <= "z") return c - "a" + 8'd26;
		if (c >= "0" && c <= "9") return c - "0" + 8'd52;
		if (c == "-") return 8'd62;
		if (c == "_") return 8'd63;
		return 8'hFF;
	endfunction

	task automatic clear_record();
		rem_bits = '0;
		rem_cnt = '0;
		nbytes = '0;
		for (int i = 0; i < 4; i++) hold[i] = '0;
		crc = 32'hFFFFFFFF;
		phase = PH_HEADER;
		field_left = '0;
		cands_left = '0;
		cand_idx = '0;
		err = ST_OK;
	endtask

	task automatic stop_parse(input status_t code);
		err = code;
		phase = PH_STOP;
	endtask

	task automatic parse_field_byte(input logic [7:0] b, input int pos, inout result_t r);
		logic [7:0] magic [4];
		magic = '{"T", "L", "S", "1"};
		case (phase)
			PH_HEADER: begin
				if (pos < 4) begin
					if (b != magic[pos]) stop_parse(ST_MAGIC);
				end else if (pos == 4) begin
					if (b != 8'd1) stop_parse(ST_VERSION);
				end else if (pos == 5) begin
					if (b > lim.max_role) stop_parse(ST_ROLE);
				end else if (pos == 6) begin
					cands_left = {8'd0, b};
				end else if (pos == 7) begin
					cands_left[15:8] = b;
				end else begin
					field_left |= {24'd0, b} << (8 * ((pos - 8) & 3));
					if (pos == 11) begin
						if (cands_left > lim.max_cands || field_left > lim.max_desc)
							stop_parse(ST_MALFORMED);
						else if (field_left == 0)
							stop_parse(ST_EMPTY_DESC);
						else
							phase = PH_DESC;
					end
				end
			end
			PH_DESC: begin
				r.data_byte = b;
				r.data_valid = 1'b1;
				field_left--;
				if (field_left == 0) phase = (cands_left != 0) ? PH_LEN_LO : PH_DONE;
			end
			PH_LEN_LO: begin
				field_left = {24'd0, b};
				phase = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				field_left[15:8] = b;
				if (field_left > lim.max_clen) stop_parse(ST_CAND_TRUNC);
				else if (field_left == 0) stop_parse(ST_EMPTY_CAND);
				else phase = PH_CDATA;
			end
			PH_CDATA: begin
				r.data_byte = b;
				r.data_valid = 1'b1;
				r.data_kind = 1'b1;
				r.candidate_number = cand_idx;
				field_left--;
				if (field_left == 0) begin
					cands_left--;
					cand_idx++;
					phase = (cands_left != 0) ? PH_LEN_LO : PH_DONE;
				end
			end
			default: ;
		endcase
	endtask

	function automatic status_t record_status();
		if (err == ST_BAD_CHAR || err == ST_TOO_LONG) return err;
		if (nbytes < 16) return ST_TRUNCATED;
		if (err == ST_MAGIC || err == ST_VERSION) return err;
		if (~crc != {hold[3], hold[2], hold[1], hold[0]}) return ST_CRC;
		if (err != ST_OK) return err;
		case (phase)
			PH_DESC:              return ST_MALFORMED;
			PH_LEN_LO, PH_LEN_HI: return ST_LEN_MISSING;
			PH_CDATA:             return ST_CAND_TRUNC;
			PH_DONE:              return ST_OK;
			default:              return ST_TRUNCATED;
		endcase
	endfunction

	task automatic predict_char(input logic [7:0] c, input logic last);
		result_t    r;
		logic [7:0] v;
		logic [11:0] acc;
		int         n;
		r = '0;
		if (err != ST_BAD_CHAR && err != ST_TOO_LONG &&
				!(c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A || c == "=")) begin
			v = sextet(c);
			if (v == 8'hFF) begin
				err = ST_BAD_CHAR;
			end else begin
				acc = {rem_bits, v[5:0]};
				n = rem_cnt + 6;
				if (n >= 8) begin
					n -= 8;
					if (nbytes >= 4096) begin
						err = ST_TOO_LONG;
					end else begin
						if (nbytes >= 4) begin
							crc = crc_step(crc, hold[0]);
							parse_field_byte(hold[0], nbytes - 4, r);
						end
						hold[0] = hold[1];
						hold[1] = hold[2];
						hold[2] = hold[3];
						hold[3] = 8'(acc >> n);
						nbytes++;
					end
				end
				rem_bits = 6'(acc & ((12'd1 << n) - 1));
				rem_cnt = 3'(n);
			end
		end
		if (last) begin
			r.done_res = 1'b1;
			r.status = record_status();
			clear_record();
		end
		expected_q.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t e;
		int      errs;
		errs = 0;
		if (!arst_n) begin
			lim <= '{max_desc: 12'd2048, max_cands: 8'd16, max_clen: 12'd256, max_role: 8'd1};
			clear_record();
			expected_q.delete();
			fail_count <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MAX_DESC:  lim.max_desc <= cfg_data;
					REG_MAX_CANDS: lim.max_cands <= cfg_data[7:0];
					REG_MAX_CLEN:  lim.max_clen <= cfg_data;
					REG_MAX_ROLE:  lim.max_role <= cfg_data[7:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					$error("result with nothing expected");
					errs++;
				end else begin
					e = expected_q.pop_front();
					if (data_byte !== e.data_byte) begin
						$error("data_byte exp %0h got %0h", e.data_byte, data_byte);
						errs++;
					end
					if (data_valid !== e.data_valid) begin
						$error("data_valid exp %0d got %0d", e.data_valid, data_valid);
						errs++;
					end
					if (data_kind !== e.data_kind) begin
						$error("data_kind exp %0d got %0d", e.data_kind, data_kind);
						errs++;
					end
					if (candidate_number !== e.candidate_number) begin
						$error("candidate_number exp %0d got %0d", e.candidate_number,
							candidate_number);
						errs++;
					end
					if (done_res !== e.done_res) begin
						$error("done_res exp %0d got %0d", e.done_res, done_res);
						errs++;
					end
					if (status !== e.status) begin
						$error("status exp %0d got %0d", e.status, status);
						errs++;
					end
				end
			end
			if (in_valid && in_ready) predict_char(symbol, final_char);
			if (errs != 0) fail_count <= fail_count + errs;
		end
	end

	assign pending = expected_q.size();
endmodule

// ----- test/tb_top.sv -----
// Testbench top for session_code_stream_decoder_core: drives characters of
// encoded records (good, damaged and noise) and register writes; scsd_checker checks.
// Depends on scsd_pkg, scsd_checker and the decoder RTL.
module tb_top import scsd_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  symbol = '0;
	logic        final_char = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  data_byte;
	logic        data_valid;
	logic        data_kind;
	logic [7:0]  candidate_number;
	logic        done_res;
	logic [3:0]  status;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_index = '0;
	logic [11:0] cfg_data = '0;
	int          fail_count;
	int          pending;
	int          chars_sent;
	bit          hold_off_done;
	bit          stim_done;

	logic [7:0] rec [$];
	logic [7:0] text [$];

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	session_code_stream_decoder_core i_dut (.*);

	scsd_checker i_chk (.*);

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 40) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [7:0] b64_char(input logic [5:0] v);
		if (v < 26) return 8'("A" + v);
		if (v < 52) return 8'("a" + v - 26);
		if (v < 62) return 8'("0" + v - 52);
		return (v == 62) ? "-" : "_";
	endfunction

	// valid stays high into the next call when no gap follows
	task automatic send_char(input logic [7:0] c, input logic last);
		int g;
		in_valid <= 1'b1;
		symbol <= c;
		final_char <= last;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		chars_sent++;
		g = gap_len();
		if (g != 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic add_crc();
		logic [31:0] c;
		c = 32'hFFFFFFFF;
		foreach (rec[i]) c = crc_byte(c, rec[i]);
		c = ~c;
		for (int i = 0; i < 4; i++) rec.push_back(c[8*i +: 8]);
	endtask

	// builds a record; corrupt selects a random damage
	task automatic build_record(input int desc_len, input int ncand, input int max_clen,
			input logic [7:0] role, input int corrupt);
		int l;
		rec.delete();
		rec = '{"T", "L", "S", "1", 8'd1, role, 8'(ncand), 8'(ncand >> 8),
			8'(desc_len), 8'(desc_len >> 8), 8'd0, 8'd0};
		repeat (desc_len) rec.push_back(8'($urandom));
		for (int k = 0; k < ncand; k++) begin
			l = $urandom_range(1, max_clen);
			rec.push_back(8'(l));
			rec.push_back(8'(l >> 8));
			repeat (l) rec.push_back(8'($urandom));
		end
		if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 3)) rec.push_back(8'($urandom));
		add_crc();
		case (corrupt)
			1: rec[$urandom_range(0, rec.size() - 1)] ^= 8'(1 << $urandom_range(0, 7));
			2: repeat ($urandom_range(1, rec.size() - 1)) void'(rec.pop_back());
			3: begin
				rec[$urandom_range(0, 11)] = 8'($urandom);
				for (int i = 0; i < 4; i++) void'(rec.pop_back());
				add_crc();
			end
			default: ;
		endcase
	endtask

	task automatic encode_record(input int noise);
		logic [11:0] acc;
		int n;
		text.delete();
		acc = '0;
		n = 0;
		foreach (rec[i]) begin
			acc = {acc[3:0], rec[i]};
			n += 8;
			while (n >= 6) begin
				n -= 6;
				text.push_back(b64_char(6'(acc >> n)));
			end
		end
		if (n > 0) text.push_back(b64_char(6'(acc << (6 - n))));
		if ($urandom_range(0, 3) == 0) text.push_back("=");
		if (noise) begin
			case ($urandom_range(0, 2))
				0: text.insert($urandom_range(0, text.size()), 8'($urandom));
				1: text.insert($urandom_range(0, text.size()), " ");
				default: text.insert($urandom_range(0, text.size()), 8'h0A);
			endcase
		end
	endtask

	task automatic send_text();
		foreach (text[i]) send_char(text[i], i == text.size() - 1);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [11:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= 8'(idx);
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0 || out_valid) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_limits(input logic [11:0] md, input logic [7:0] mc,
			input logic [11:0] ml, input logic [7:0] mr);
		drain();
		write_reg(REG_MAX_DESC, md);
		write_reg(REG_MAX_CANDS, 12'(mc));
		write_reg(REG_MAX_CLEN, ml);
		write_reg(REG_MAX_ROLE, 12'(mr));
		write_reg(reg_idx_t'(2'd0), md);
		cfg_valid <= 1'b1;
		cfg_index <= 8'd9;
		cfg_data <= 12'hFFF;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int p;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: characters of each kind (letters, digits, -, _, skip and bad) and special cases
		send_char("A", 1'b1);
		send_char("!", 1'b0);
		send_char("T", 1'b1);
		send_char(8'hFF, 1'b0);
		send_char(8'h09, 1'b0);
		send_char(8'h0D, 1'b0);
		send_char("_", 1'b0);
		send_char("-", 1'b0);
		send_char("z", 1'b0);
		send_char("9", 1'b1);
		build_record(3, 2, 3, 8'd1, 0);
		encode_record(0);
		send_text();
		build_record(1, 0, 1, 8'd0, 0);
		encode_record(0);
		send_text();
		// empty description, empty candidate
		rec = '{"T", "L", "S", "1", 8'd1, 8'd0, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
		add_crc();
		encode_record(0);
		send_text();
		rec = '{"T", "L", "S", "1", 8'd1, 8'd0, 8'd1, 8'd0, 8'd1, 8'd0, 8'd0, 8'd0,
			8'h55, 8'd0, 8'd0};
		add_crc();
		encode_record(0);
		send_text();
		set_limits(12'd1, 8'd0, 12'd1, 8'd0);
		build_record(1, 0, 1, 8'd0, 0);
		encode_record(0);
		send_text();
		build_record(2, 1, 1, 8'd0, 0);
		encode_record(0);
		send_text();
		set_limits(12'd4095, 8'd255, 12'd4095, 8'd255);
		build_record(3, 3, 4, 8'd255, 0);
		encode_record(0);
		send_text();
		set_limits(12'd12, 8'd4, 12'd8, 8'd3);
		// random records with long receiver hold-off in its own process
		while (chars_sent < 1650) begin
			p = $urandom_range(0, 99);
			build_record($urandom_range(1, 14), $urandom_range(0, 5), $urandom_range(1, 9),
				8'($urandom_range(0, 4)), (p < 55) ? 0 : $urandom_range(1, 3));
			encode_record(p > 85);
			send_text();
			if ($urandom_range(0, 30) == 0)
				set_limits(12'($urandom_range(1, 16)), 8'($urandom_range(0, 6)),
					12'($urandom_range(1, 10)), 8'($urandom_range(0, 255)));
		end
		drain();
		stim_done = 1'b1;
	end

	initial begin
		int g;
		repeat (9) @(posedge clk);
		forever begin
			if (!hold_off_done && chars_sent > 800) begin
				out_ready <= 1'b0;
				repeat (60) @(posedge clk);
				hold_off_done = 1'b1;
			end else begin
				g = gap_len();
				if (g != 0) begin
					out_ready <= 1'b0;
					repeat (g) @(posedge clk);
				end
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	initial begin
		wait (stim_done);
		if (fail_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("RESULT: ERROR");
		$finish;
	end
endmodule

// ----- sim.f -----
hdl/scsd_pkg.sv
hdl/scsd_cfg_regs.sv
hdl/scsd_decode_core.sv
hdl/session_code_stream_decoder_core.sv
hdl/scsd_checker.sv
test/scsd_checker.sv
test/tb_top.sv
